/* hw/rtl/rarmt_pkg.sv */
package rarmt_pkg;

    localparam int SIZE_DEF = 1024;
    localparam int IDX_W    = 10;
    localparam int DAT_W    = 32;

    localparam logic [IDX_W-1:0] LOW_BOUND_RST  = 10'd0;
    localparam logic [IDX_W-1:0] HIGH_BOUND_RST = 10'd1023;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic {
        ST_DONE    = 1'b0,
        ST_INVALID = 1'b1
    } t_status;

    typedef enum logic {
        CFG_LOW_BOUND  = 1'b0,
        CFG_HIGH_BOUND = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] ql;
        logic [IDX_W-1:0] qr;
        logic [DAT_W-1:0] amt;
        logic             ok;
        logic [IDX_W-1:0] lb;
        logic [IDX_W-1:0] hb;
    } t_item;

    typedef struct packed {
        logic valid;
        logic clear;
    } t_fctl;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bstat;

endpackage

/* hw/rtl/range_add_range_min_tree_unit.sv */
// Channel   Direction  Handshake                  Payload
// request   in         start high, busy low       i_operation, i_range_low, i_range_high, i_amount
// result    out        o_done for one cycle       o_minimum, o_status
// config    in         i_cfg_valid, o_cfg_ready   i_cfg_index, i_cfg_data
//
// The time a valid request takes grows with the tree nodes that it visits: it is shortest when
// the range is the whole span and longest for a wide add, and the single port of the node
// memory sets it. With the engine idle, a request with an invalid range is written into the
// request queue, and the engine registers its result without visiting the tree.
// After reset and after every configuration write the whole node memory is cleared, during
// which busy is high. Up to two requests queue ahead of the engine.
// The receiver cannot stall; o_done marks every result for exactly one cycle.
module range_add_range_min_tree_unit #(
    parameter int SIZE = rarmt_pkg::SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_operation,
    input  logic [rarmt_pkg::IDX_W-1:0]        i_range_low,
    input  logic [rarmt_pkg::IDX_W-1:0]        i_range_high,
    input  logic signed [rarmt_pkg::DAT_W-1:0] i_amount,
    output logic                               o_done,
    output logic signed [rarmt_pkg::DAT_W-1:0] o_minimum,
    output logic                               o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [rarmt_pkg::IDX_W-1:0]        i_cfg_data
);

    rarmt_pkg::t_item  item;
    rarmt_pkg::t_fctl  ctl;
    rarmt_pkg::t_bstat bstat;

    rarmt_front #(.SIZE(SIZE)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_operation  (i_operation),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_amount     (i_amount),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_item       (item),
        .o_ctl        (ctl),
        .i_bstat      (bstat)
    );

    rarmt_back #(.SIZE(SIZE)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_ctl     (ctl),
        .o_bstat   (bstat),
        .o_done    (o_done),
        .o_minimum (o_minimum),
        .o_status  (o_status)
    );

endmodule

/* hw/rtl/rarmt_front.sv */
module rarmt_front #(
    parameter int SIZE = rarmt_pkg::SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_operation,
    input  logic [rarmt_pkg::IDX_W-1:0]   i_range_low,
    input  logic [rarmt_pkg::IDX_W-1:0]   i_range_high,
    input  logic signed [rarmt_pkg::DAT_W-1:0] i_amount,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [rarmt_pkg::IDX_W-1:0]   i_cfg_data,
    output rarmt_pkg::t_item              o_item,
    output rarmt_pkg::t_fctl              o_ctl,
    input  rarmt_pkg::t_bstat             i_bstat
);

    logic [rarmt_pkg::IDX_W-1:0] r_lb;
    logic [rarmt_pkg::IDX_W-1:0] r_hb;
    rarmt_pkg::t_item            r_q [0:1];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;
    logic                        accept;
    logic                        ok;
    logic [rarmt_pkg::IDX_W-1:0] span;
    rarmt_pkg::t_item            n_item;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_cnt == 2'd2) || i_bstat.clearing;
    assign accept      = i_start && !o_busy;
    assign span        = r_hb - r_lb;

    always_comb begin
        ok = (r_lb <= r_hb) && (32'(span) < 32'(SIZE)) && (i_range_low <= i_range_high)
             && (i_range_low >= r_lb) && (i_range_high <= r_hb);
        n_item.op  = rarmt_pkg::t_op'(i_operation);
        n_item.ql  = i_range_low;
        n_item.qr  = i_range_high;
        n_item.amt = i_amount;
        n_item.ok  = ok;
        n_item.lb  = r_lb;
        n_item.hb  = r_hb;
    end

    assign o_item      = r_q[r_rp];
    assign o_ctl.valid = (r_cnt != 2'd0);
    assign o_ctl.clear = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lb  <= rarmt_pkg::LOW_BOUND_RST;
            r_hb  <= rarmt_pkg::HIGH_BOUND_RST;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                case (rarmt_pkg::t_cfg_idx'(i_cfg_index))
                    rarmt_pkg::CFG_LOW_BOUND:  r_lb <= i_cfg_data;
                    rarmt_pkg::CFG_HIGH_BOUND: r_hb <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_q[r_wp] <= n_item;
                r_wp      <= ~r_wp;
            end
            if (i_bstat.pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_bstat.pop);
        end
    end

endmodule

/* hw/rtl/rarmt_back.sv */
module rarmt_back #(
    parameter int SIZE = rarmt_pkg::SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rarmt_pkg::t_item                  i_item,
    input  rarmt_pkg::t_fctl                  i_ctl,
    output rarmt_pkg::t_bstat                 o_bstat,
    output logic                              o_done,
    output logic signed [rarmt_pkg::DAT_W-1:0] o_minimum,
    output logic                              o_status
);

    localparam int IW    = rarmt_pkg::IDX_W;
    localparam int DW    = rarmt_pkg::DAT_W;
    localparam int MEM_D = 2 * SIZE;
    localparam int ID_W  = $clog2(MEM_D);
    localparam int STK_D = $clog2(SIZE) + 1;
    localparam int SI_W  = $clog2(STK_D);
    localparam int SP_W  = $clog2(STK_D + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VISIT, S_LEAF, S_PD, S_PD_L, S_PD_R,
        S_DESC, S_RET, S_PU_L, S_PU_R
    } t_state;

    typedef enum logic [1:0] {
        PH_ONE, PH_FIRST, PH_SECOND
    } t_phase;

    function automatic logic [IW-1:0] f_mid(input logic [IW-1:0] nl, input logic [IW-1:0] nr);
        logic [IW:0] sum;
        sum = {1'b0, nl} + {1'b0, nr};
        return sum[IW:1];
    endfunction

    function automatic logic [ID_W-1:0] f_roff(input logic [IW-1:0] nl,
                                               input logic [IW-1:0] nr);
        logic [IW:0] half;
        half = {1'b0, f_mid(nl, nr)} - {1'b0, nl} + (IW+1)'(1);
        return ID_W'({half, 1'b0});
    endfunction

    function automatic logic [DW-1:0] f_smin(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    logic [2*DW-1:0] mem [0:MEM_D-1];
    logic [2*DW-1:0] r_rdata;
    logic            mem_re;
    logic            mem_we;
    logic [ID_W-1:0] mem_raddr;
    logic [ID_W-1:0] mem_waddr;
    logic [2*DW-1:0] mem_wdata;

    t_state          r_state;
    logic [ID_W-1:0] r_clr;
    logic [SP_W-1:0] r_sp;
    logic [ID_W-1:0] r_id;
    logic [IW-1:0]   r_nl;
    logic [IW-1:0]   r_nr;
    logic [IW-1:0]   r_ql;
    logic [IW-1:0]   r_qr;
    rarmt_pkg::t_op  r_op;
    logic [DW-1:0]   r_amt;
    logic [DW-1:0]   r_pend;
    logic [DW-1:0]   r_ret;
    logic [DW-1:0]   r_lmin;
    logic            r_done;
    logic [DW-1:0]   r_min;
    logic            r_status;

    logic [ID_W-1:0] r_stk_id  [0:STK_D-1];
    logic [IW-1:0]   r_stk_nl  [0:STK_D-1];
    logic [IW-1:0]   r_stk_nr  [0:STK_D-1];
    logic [IW-1:0]   r_stk_ql  [0:STK_D-1];
    logic [IW-1:0]   r_stk_qr  [0:STK_D-1];
    t_phase          r_stk_ph  [0:STK_D-1];
    logic [DW-1:0]   r_stk_acc [0:STK_D-1];

    logic [DW-1:0]   rd_min;
    logic [DW-1:0]   rd_pend;
    logic [IW-1:0]   mid;
    logic [ID_W-1:0] rid;
    logic [SP_W-1:0] spm1;
    logic [SI_W-1:0] pidx;
    logic [SI_W-1:0] widx;
    logic [IW-1:0]   p_mid;
    logic [ID_W-1:0] p_rid;
    logic            exact;

    assign rd_min  = r_rdata[2*DW-1:DW];
    assign rd_pend = r_rdata[DW-1:0];
    assign mid     = f_mid(r_nl, r_nr);
    assign rid     = r_id + f_roff(r_nl, r_nr);
    assign spm1    = r_sp - SP_W'(1);
    assign pidx    = spm1[SI_W-1:0];
    assign widx    = r_sp[SI_W-1:0];
    assign p_mid   = f_mid(r_stk_nl[pidx], r_stk_nr[pidx]);
    assign p_rid   = r_stk_id[pidx] + f_roff(r_stk_nl[pidx], r_stk_nr[pidx]);
    assign exact   = (r_nl == r_ql) && (r_nr == r_qr);

    assign o_bstat.pop      = (r_state == S_IDLE) && i_ctl.valid && !i_ctl.clear;
    assign o_bstat.clearing = (r_state == S_CLEAR);
    assign o_done           = r_done;
    assign o_minimum        = r_min;
    assign o_status         = r_status;

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_id;
        mem_we    = 1'b0;
        mem_waddr = r_id;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_VISIT: begin
                mem_re = 1'b1;
            end
            S_LEAF: begin
                mem_we    = (r_op == rarmt_pkg::OP_ADD);
                mem_wdata = {rd_min + r_amt, rd_pend + r_amt};
            end
            S_PD: begin
                mem_we    = 1'b1;
                mem_wdata = {rd_min, {DW{1'b0}}};
                mem_re    = (rd_pend != '0);
                mem_raddr = r_id + ID_W'(1);
            end
            S_PD_L: begin
                mem_we    = 1'b1;
                mem_waddr = r_id + ID_W'(1);
                mem_wdata = {rd_min + r_pend, rd_pend + r_pend};
                mem_re    = 1'b1;
                mem_raddr = rid;
            end
            S_PD_R: begin
                mem_we    = 1'b1;
                mem_waddr = rid;
                mem_wdata = {rd_min + r_pend, rd_pend + r_pend};
            end
            S_RET: begin
                mem_re    = (r_op == rarmt_pkg::OP_ADD) && (r_sp != '0)
                            && (r_stk_ph[pidx] != PH_FIRST);
                mem_raddr = r_stk_id[pidx] + ID_W'(1);
            end
            S_PU_L: begin
                mem_re    = 1'b1;
                mem_raddr = rid;
            end
            S_PU_R: begin
                mem_we    = 1'b1;
                mem_wdata = {f_smin(r_lmin, rd_min), {DW{1'b0}}};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_sp    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.clear) begin
                r_state <= S_CLEAR;
                r_clr   <= '0;
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + ID_W'(1);
                        if (r_clr == ID_W'(MEM_D - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_ctl.valid) begin
                            if (!i_item.ok) begin
                                r_done   <= 1'b1;
                                r_min    <= '0;
                                r_status <= rarmt_pkg::ST_INVALID;
                            end else begin
                                r_id    <= '0;
                                r_nl    <= i_item.lb;
                                r_nr    <= i_item.hb;
                                r_ql    <= i_item.ql;
                                r_qr    <= i_item.qr;
                                r_op    <= i_item.op;
                                r_amt   <= i_item.amt;
                                r_sp    <= '0;
                                r_state <= S_VISIT;
                            end
                        end
                    end
                    S_VISIT: begin
                        r_state <= exact ? S_LEAF : S_PD;
                    end
                    S_LEAF: begin
                        r_ret   <= rd_min;
                        r_state <= S_RET;
                    end
                    S_PD: begin
                        r_pend  <= rd_pend;
                        r_state <= (rd_pend != '0) ? S_PD_L : S_DESC;
                    end
                    S_PD_L: begin
                        r_state <= S_PD_R;
                    end
                    S_PD_R: begin
                        r_state <= S_DESC;
                    end
                    S_DESC: begin
                        r_stk_id[widx] <= r_id;
                        r_stk_nl[widx] <= r_nl;
                        r_stk_nr[widx] <= r_nr;
                        r_stk_ql[widx] <= r_ql;
                        r_stk_qr[widx] <= r_qr;
                        r_sp           <= r_sp + SP_W'(1);
                        if (r_qr <= mid) begin
                            r_stk_ph[widx] <= PH_ONE;
                            r_id           <= r_id + ID_W'(1);
                            r_nr           <= mid;
                        end else if (r_ql > mid) begin
                            r_stk_ph[widx] <= PH_ONE;
                            r_id           <= rid;
                            r_nl           <= mid + IW'(1);
                        end else begin
                            r_stk_ph[widx] <= PH_FIRST;
                            r_id           <= r_id + ID_W'(1);
                            r_nr           <= mid;
                            r_qr           <= mid;
                        end
                        r_state <= S_VISIT;
                    end
                    S_RET: begin
                        if (r_sp == '0) begin
                            r_done   <= 1'b1;
                            r_min    <= (r_op == rarmt_pkg::OP_QUERY) ? r_ret : '0;
                            r_status <= rarmt_pkg::ST_DONE;
                            r_state  <= S_IDLE;
                        end else if (r_stk_ph[pidx] == PH_FIRST) begin
                            r_stk_ph[pidx]  <= PH_SECOND;
                            r_stk_acc[pidx] <= r_ret;
                            r_id            <= p_rid;
                            r_nl            <= p_mid + IW'(1);
                            r_nr            <= r_stk_nr[pidx];
                            r_ql            <= p_mid + IW'(1);
                            r_qr            <= r_stk_qr[pidx];
                            r_state         <= S_VISIT;
                        end else begin
                            if (r_stk_ph[pidx] == PH_SECOND) begin
                                r_ret <= f_smin(r_stk_acc[pidx], r_ret);
                            end
                            // A query leaves the node minima as they are on the way up.
                            if (r_op == rarmt_pkg::OP_ADD) begin
                                r_id    <= r_stk_id[pidx];
                                r_nl    <= r_stk_nl[pidx];
                                r_nr    <= r_stk_nr[pidx];
                                r_ql    <= r_stk_ql[pidx];
                                r_qr    <= r_stk_qr[pidx];
                                r_state <= S_PU_L;
                            end else begin
                                r_sp <= spm1;
                            end
                        end
                    end
                    S_PU_L: begin
                        r_lmin  <= rd_min;
                        r_state <= S_PU_R;
                    end
                    S_PU_R: begin
                        r_sp    <= spm1;
                        r_state <= S_RET;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_sp) <= 32'(STK_D)))
        else $error("descent stack overflow");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bstat.pop && i_item.ok) |=> (r_state == S_VISIT))
        else $error("valid request not started");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_RET || $past(r_state) == S_IDLE))
        else $error("result strobe from wrong state");

    a_pull_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PU_R && !i_ctl.clear) |=> (r_sp == $past(r_sp) - SP_W'(1)))
        else $error("stack not popped after rebuild");

endmodule

/* tb/sv/tb_range_add_range_min_tree_unit.sv */
`timescale 1ns / 100ps

module tb_range_add_range_min_tree_unit;

    localparam int SLOTS = 2 * rarmt_pkg::SIZE_DEF;
    localparam int IW    = rarmt_pkg::IDX_W;
    localparam int DW    = rarmt_pkg::DAT_W;

    typedef struct {
        rarmt_pkg::t_op op;
        logic [IW-1:0]  lo;
        logic [IW-1:0]  hi;
        logic [DW-1:0]  amt;
    } t_req;

    typedef struct {
        logic [DW-1:0]      minimum;
        rarmt_pkg::t_status status;
    } t_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_operation = 1'b0;
    logic [IW-1:0]        i_range_low = '0;
    logic [IW-1:0]        i_range_high = '0;
    logic signed [DW-1:0] i_amount = '0;
    logic                 o_done;
    logic signed [DW-1:0] o_minimum;
    logic                 o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = 1'b0;
    logic [IW-1:0]        i_cfg_data = '0;

    range_add_range_min_tree_unit dut (.*);

    always #5 i_clk = ~i_clk;

    logic [DW-1:0] node_min [SLOTS];
    logic [DW-1:0] node_pend [SLOTS];
    logic [IW-1:0] bound_lo = rarmt_pkg::LOW_BOUND_RST;
    logic [IW-1:0] bound_hi = rarmt_pkg::HIGH_BOUND_RST;

    t_req pending_reqs [$];
    t_res expected_results [$];
    t_req cur_req;
    int   idle_pct = 0;
    int   n_errors = 0;
    int   n_results = 0;
    int   n_queries = 0;
    int   n_adds = 0;
    int   n_invalid = 0;

    function automatic logic [DW-1:0] smin(logic [DW-1:0] a, logic [DW-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic void add_to_node(int unsigned id, logic [DW-1:0] v);
        if (id < SLOTS) begin
            node_min[id] += v;
            node_pend[id] += v;
        end
    endfunction

    function automatic logic [DW-1:0] node_value(int unsigned id);
        return (id < SLOTS) ? node_min[id] : '0;
    endfunction

    function automatic void push_pending(int unsigned id, int unsigned l, int unsigned r);
        int unsigned mid;
        if (l == r || id >= SLOTS) return;
        if (node_pend[id] != '0) begin
            mid = (l + r) >> 1;
            add_to_node(id + 1, node_pend[id]);
            add_to_node(id + 2 * (mid - l + 1), node_pend[id]);
            node_pend[id] = '0;
        end
    endfunction

    function automatic void tree_add(int unsigned id, int unsigned nl, int unsigned nr,
                                     int unsigned ql, int unsigned qr, logic [DW-1:0] v);
        int unsigned mid;
        int unsigned rid;
        if (nl == ql && nr == qr) begin
            add_to_node(id, v);
            return;
        end
        push_pending(id, nl, nr);
        mid = (nl + nr) >> 1;
        rid = id + 2 * (mid - nl + 1);
        if (qr <= mid) begin
            tree_add(id + 1, nl, mid, ql, qr, v);
        end else if (mid + 1 <= ql) begin
            tree_add(rid, mid + 1, nr, ql, qr, v);
        end else begin
            tree_add(id + 1, nl, mid, ql, mid, v);
            tree_add(rid, mid + 1, nr, mid + 1, qr, v);
        end
        if (id < SLOTS) node_min[id] = smin(node_value(id + 1), node_value(rid));
    endfunction

    function automatic logic [DW-1:0] tree_min(int unsigned id, int unsigned nl,
                                               int unsigned nr, int unsigned ql,
                                               int unsigned qr);
        int unsigned mid;
        int unsigned rid;
        if (nl == ql && nr == qr) return node_value(id);
        push_pending(id, nl, nr);
        mid = (nl + nr) >> 1;
        rid = id + 2 * (mid - nl + 1);
        if (qr <= mid) return tree_min(id + 1, nl, mid, ql, qr);
        if (mid + 1 <= ql) return tree_min(rid, mid + 1, nr, ql, qr);
        return smin(tree_min(id + 1, nl, mid, ql, mid),
                    tree_min(rid, mid + 1, nr, mid + 1, qr));
    endfunction

    function automatic void clear_tree();
        for (int i = 0; i < SLOTS; i++) begin
            node_min[i] = '0;
            node_pend[i] = '0;
        end
    endfunction

    function automatic void predict_result(t_req r);
        t_res e;
        logic ok;
        ok = bound_lo <= bound_hi && r.lo <= r.hi && r.lo >= bound_lo && r.hi <= bound_hi;
        e.minimum = '0;
        e.status = ok ? rarmt_pkg::ST_DONE : rarmt_pkg::ST_INVALID;
        if (!ok) begin
            n_invalid++;
        end else if (r.op == rarmt_pkg::OP_ADD) begin
            n_adds++;
            tree_add(0, bound_lo, bound_hi, r.lo, r.hi, r.amt);
        end else begin
            n_queries++;
            e.minimum = tree_min(0, bound_lo, bound_hi, r.lo, r.hi);
        end
        expected_results.push_back(e);
    endfunction

    function automatic t_req make_req(rarmt_pkg::t_op op, int lo, int hi, logic [DW-1:0] amt);
        t_req r;
        r.op = op;
        r.lo = IW'(lo);
        r.hi = IW'(hi);
        r.amt = amt;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   lo;
        int   sel;
        r.op = $urandom_range(1, 0) ? rarmt_pkg::OP_QUERY : rarmt_pkg::OP_ADD;
        sel = $urandom_range(99, 0);
        if (sel < 15 || bound_lo > bound_hi) begin
            r.lo = IW'($urandom);
            r.hi = IW'($urandom);
        end else begin
            lo = int'($urandom_range(bound_hi, bound_lo));
            r.lo = IW'(lo);
            r.hi = (sel < 55) ? IW'($urandom_range(bound_hi, lo))
                              : IW'($urandom_range((lo + 7 > bound_hi) ? bound_hi : lo + 7, lo));
        end
        sel = $urandom_range(9, 0);
        if (sel < 5) r.amt = $urandom_range(200, 0) - 100;
        else if (sel == 5) r.amt = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else r.amt = $urandom;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_result(cur_req);
            if (!start || !busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    start <= 1'b1;
                    i_operation <= cur_req.op;
                    i_range_low <= cur_req.lo;
                    i_range_high <= cur_req.hi;
                    i_amount <= cur_req.amt;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected result: minimum %0d status %0d", o_minimum, o_status);
            end else begin
                e = expected_results.pop_front();
                if (o_minimum !== e.minimum || o_status !== e.status) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("Mismatch: expected minimum %0d status %0d, got %0d %0d",
                                 $signed(e.minimum), e.status, o_minimum, o_status);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(rarmt_pkg::t_cfg_idx idx, logic [IW-1:0] value);
        wait_drained();
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == rarmt_pkg::CFG_LOW_BOUND) bound_lo = value;
        else bound_hi = value;
        clear_tree();
    endtask

    task automatic random_phase(int pct, int count, bit pause_midway);
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) wait_drained();
            pending_reqs.push_back(random_req());
        end
        wait_drained();
    endtask

    initial begin
        clear_tree();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 0, 1023, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_ADD, 0, 1023, 32'h7FFF_FFFF));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_ADD, 0, 0, 32'h0000_0001));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 0, 1023, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 0, 0, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_ADD, 1023, 1023, 32'h8000_0000));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 1023, 1023, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 1, 1022, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_ADD, 300, 700, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 299, 701, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_ADD, 5, 4, 32'h1234_5678));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 1023, 0, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 512, 512, 0));
        wait_drained();
        random_phase(0, 250, 1'b1);

        write_reg(rarmt_pkg::CFG_LOW_BOUND, 100);
        write_reg(rarmt_pkg::CFG_HIGH_BOUND, 200);
        pending_reqs.push_back(make_req(rarmt_pkg::OP_ADD, 50, 150, 32'h0000_0010));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 150, 250, 0));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_ADD, 100, 200, 32'h8000_0000));
        pending_reqs.push_back(make_req(rarmt_pkg::OP_QUERY, 100, 200, 0));
        random_phase(88, 200, 1'b0);

        write_reg(rarmt_pkg::CFG_LOW_BOUND, 1023);
        write_reg(rarmt_pkg::CFG_HIGH_BOUND, 1023);
        random_phase(37, 60, 1'b0);

        write_reg(rarmt_pkg::CFG_LOW_BOUND, 0);
        write_reg(rarmt_pkg::CFG_HIGH_BOUND, 0);
        random_phase(0, 60, 1'b0);

        write_reg(rarmt_pkg::CFG_LOW_BOUND, 900);
        write_reg(rarmt_pkg::CFG_HIGH_BOUND, 3);
        random_phase(37, 40, 1'b0);

        write_reg(rarmt_pkg::CFG_LOW_BOUND, 0);
        write_reg(rarmt_pkg::CFG_HIGH_BOUND, 1023);
        random_phase(37, 250, 1'b0);

        write_reg(rarmt_pkg::CFG_LOW_BOUND, 512);
        write_reg(rarmt_pkg::CFG_HIGH_BOUND, 777);
        random_phase(88, 150, 1'b0);

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d adds, %0d queries and %0d invalid requests over seven bounds,",
                 n_adds, n_queries, n_invalid);
        $display("with %0d results received and %0d mismatches.", n_results, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rarmt_pkg.sv
hw/rtl/rarmt_front.sv
hw/rtl/rarmt_back.sv
hw/rtl/range_add_range_min_tree_unit.sv
tb/sv/tb_range_add_range_min_tree_unit.sv
